### design/uartbq_pkg.sv
// Shared types, sizes and codes for the buffered UART transmit and receive queues.
package uartbq_pkg;

    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;

    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);

    localparam int BYTE_W   = 8;
    localparam int ACT_W    = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [ACT_W-1:0]    t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_WRITE    = 3'd0;
    localparam t_action ACT_TX_DONE  = 3'd1;
    localparam t_action ACT_RECEIVE  = 3'd2;
    localparam t_action ACT_READ     = 3'd3;
    localparam t_action ACT_CLEAR_RX = 3'd4;
    localparam t_action ACT_CLEAR_TX = 3'd5;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_TX_FULL     = 3'd1;
    localparam t_status ST_EMPTY       = 3'd2;
    localparam t_status ST_ERRORED     = 3'd3;
    localparam t_status ST_RX_OVERFLOW = 3'd4;

    typedef struct packed {
        logic    send_valid;
        t_byte   send_byte;
        logic    read_valid;
        t_byte   read_byte;
        t_status status;
    } t_result;

endpackage

### design/uartbq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module uartbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/uart_buffered_tx_rx_queues.sv
// Top level of the buffered UART front end: queue control, configuration port and result register.
// An accepted input moves the state to EXEC, which writes the result register.
// No new item is taken while one is in EXEC; o_ready is high only in IDLE.
// A new item is taken while a finished result is still waiting, once the result register frees.
// Reset clears the mode, all pointers, fill counts and the holding register.
// The queue RAMs are not cleared; entries are read only after they have been written.
module uart_buffered_tx_rx_queues
    import uartbq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic                i_transmitter_idle,
    input  logic                i_frame_error,
    input  logic                i_overrun_error,
    input  logic                i_parity_error,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_send_valid,
    output logic [BYTE_W-1:0]   o_send_byte,
    output logic                o_read_valid,
    output logic [BYTE_W-1:0]   o_read_byte,
    output logic [COUNT_W-1:0]  o_receive_count,
    output logic [COUNT_W-1:0]  o_transmit_count,
    output logic [STATUS_W-1:0] o_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic                 r_mode;

    t_action              r_act;
    t_byte                r_data;
    logic                 r_idle;
    logic                 r_errs;

    logic [TX_PTR_W-1:0]  r_tx_wptr, n_tx_wptr;
    logic [TX_PTR_W-1:0]  r_tx_rptr, n_tx_rptr;
    logic [TX_FILL_W-1:0] r_tx_fill, n_tx_fill;
    logic [RX_PTR_W-1:0]  r_rx_wptr, n_rx_wptr;
    logic [RX_PTR_W-1:0]  r_rx_rptr, n_rx_rptr;
    logic [RX_FILL_W-1:0] r_rx_fill, n_rx_fill;
    t_byte                r_hold, n_hold;
    logic                 r_hold_full, n_hold_full;

    logic                 tx_we;
    logic                 rx_we;
    t_byte                tx_rdata;
    t_byte                rx_rdata;

    t_result              n_res;
    t_result              r_res;
    logic                 r_ovalid;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign prdata  = {{(APB_DW-1){1'b0}}, r_mode};
    assign cfg_wr  = psel & penable & pwrite;

    assign o_ready  = (r_state == S_IDLE) & (~r_ovalid | i_ready);
    assign in_xfer  = i_valid & o_ready;
    assign out_xfer = r_ovalid & i_ready;

    uartbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wptr),
        .i_wdata (r_data),
        .i_raddr (r_tx_rptr),
        .o_rdata (tx_rdata)
    );

    uartbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wptr),
        .i_wdata (r_data),
        .i_raddr (r_rx_rptr),
        .o_rdata (rx_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_tx_wptr   = r_tx_wptr;
        n_tx_rptr   = r_tx_rptr;
        n_tx_fill   = r_tx_fill;
        n_rx_wptr   = r_rx_wptr;
        n_rx_rptr   = r_rx_rptr;
        n_rx_fill   = r_rx_fill;
        n_hold      = r_hold;
        n_hold_full = r_hold_full;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        n_res       = '0;
        n_res.status = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_act)
                    ACT_WRITE: begin
                        if (!r_mode || (r_tx_fill == '0 && r_idle)) begin
                            n_res.send_valid = 1'b1;
                            n_res.send_byte  = r_data;
                        end else if (r_tx_fill == TX_FILL_W'(TX_DEPTH)) begin
                            n_res.status = ST_TX_FULL;
                        end else begin
                            tx_we     = 1'b1;
                            n_tx_wptr = (r_tx_wptr == TX_PTR_W'(TX_DEPTH - 1)) ?
                                        '0 : r_tx_wptr + 1'b1;
                            n_tx_fill = r_tx_fill + 1'b1;
                        end
                    end
                    ACT_TX_DONE: begin
                        if (r_mode && r_tx_fill != '0) begin
                            n_res.send_valid = 1'b1;
                            n_res.send_byte  = tx_rdata;
                            n_tx_rptr = (r_tx_rptr == TX_PTR_W'(TX_DEPTH - 1)) ?
                                        '0 : r_tx_rptr + 1'b1;
                            n_tx_fill = r_tx_fill - 1'b1;
                        end
                    end
                    ACT_RECEIVE: begin
                        if (r_mode) begin
                            if (r_errs) begin
                                n_res.status = ST_ERRORED;
                            end else if (r_rx_fill == RX_FILL_W'(RX_DEPTH)) begin
                                n_res.status = ST_RX_OVERFLOW;
                            end else begin
                                rx_we     = 1'b1;
                                n_rx_wptr = (r_rx_wptr == RX_PTR_W'(RX_DEPTH - 1)) ?
                                            '0 : r_rx_wptr + 1'b1;
                                n_rx_fill = r_rx_fill + 1'b1;
                            end
                        end else if (r_hold_full) begin
                            n_res.status = ST_RX_OVERFLOW;
                        end else begin
                            n_hold      = r_data;
                            n_hold_full = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (r_mode) begin
                            if (r_rx_fill == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_res.read_valid = 1'b1;
                                n_res.read_byte  = rx_rdata;
                                n_rx_rptr = (r_rx_rptr == RX_PTR_W'(RX_DEPTH - 1)) ?
                                            '0 : r_rx_rptr + 1'b1;
                                n_rx_fill = r_rx_fill - 1'b1;
                            end
                        end else if (r_hold_full) begin
                            n_res.read_valid = 1'b1;
                            n_res.read_byte  = r_hold;
                            n_hold_full      = 1'b0;
                        end else begin
                            n_res.status = ST_EMPTY;
                        end
                    end
                    ACT_CLEAR_RX: begin
                        n_rx_wptr   = '0;
                        n_rx_rptr   = '0;
                        n_rx_fill   = '0;
                        n_hold_full = 1'b0;
                    end
                    ACT_CLEAR_TX: begin
                        n_tx_wptr = '0;
                        n_tx_rptr = '0;
                        n_tx_fill = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_tx_wptr   <= '0;
            r_tx_rptr   <= '0;
            r_tx_fill   <= '0;
            r_rx_wptr   <= '0;
            r_rx_rptr   <= '0;
            r_rx_fill   <= '0;
            r_hold      <= '0;
            r_hold_full <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tx_wptr   <= n_tx_wptr;
            r_tx_rptr   <= n_tx_rptr;
            r_tx_fill   <= n_tx_fill;
            r_rx_wptr   <= n_rx_wptr;
            r_rx_rptr   <= n_rx_rptr;
            r_rx_fill   <= n_rx_fill;
            r_hold      <= n_hold;
            r_hold_full <= n_hold_full;
            if (cfg_wr) begin
                r_mode <= pwdata[0];
            end
            if (r_state == S_EXEC) begin
                r_ovalid <= 1'b1;
            end else if (out_xfer) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act  <= i_action;
            r_data <= i_data_byte;
            r_idle <= i_transmitter_idle;
            r_errs <= i_frame_error | i_overrun_error | i_parity_error;
        end
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_send_valid     = r_res.send_valid;
    assign o_send_byte      = r_res.send_byte;
    assign o_read_valid     = r_res.read_valid;
    assign o_read_byte      = r_res.read_byte;
    assign o_status         = r_res.status;
    assign o_receive_count  = COUNT_W'(r_rx_fill);
    assign o_transmit_count = COUNT_W'(r_tx_fill);

endmodule

### sim/uart_buffered_tx_rx_queues_tb.sv
// Testbench for the buffered UART transmit and receive queues, checking every result against a prediction.
module uart_buffered_tx_rx_queues_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uartbq_pkg::*;

    localparam logic [APB_AW-1:0] REG_BUFFERED_MODE = '0;
    localparam t_action ACT_SPARE_6 = 3'd6;
    localparam t_action ACT_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASE_ITEMS = 220;
    localparam int RANDOM_PHASES = 5;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_kind;

    typedef struct packed {
        t_action action;
        t_byte   data;
        logic    tx_idle;
        logic    frame_err;
        logic    overrun_err;
        logic    parity_err;
    } t_uart_event;

    typedef struct packed {
        logic               send_valid;
        t_byte              send_byte;
        logic               read_valid;
        t_byte              read_byte;
        logic [COUNT_W-1:0] rx_count;
        logic [COUNT_W-1:0] tx_count;
        t_status            status;
    } t_uart_response;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [ACT_W-1:0]    i_action;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                i_transmitter_idle;
    logic                i_frame_error;
    logic                i_overrun_error;
    logic                i_parity_error;
    logic                o_valid;
    logic                i_ready;
    logic                o_send_valid;
    logic [BYTE_W-1:0]   o_send_byte;
    logic                o_read_valid;
    logic [BYTE_W-1:0]   o_read_byte;
    logic [COUNT_W-1:0]  o_receive_count;
    logic [COUNT_W-1:0]  o_transmit_count;
    logic [STATUS_W-1:0] o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_byte          tx_ring [TX_DEPTH];
    t_byte          rx_ring [RX_DEPTH];
    int             tx_wr, tx_rd, tx_fill;
    int             rx_wr, rx_rd, rx_fill;
    t_byte          holding_byte;
    logic           holding_full;
    logic           model_buffered;
    t_uart_response awaited_responses[$];
    int             mismatches;
    int             cycle_count;
    int             sender_idle_pct;
    int             receiver_stall_pct;

    uart_buffered_tx_rx_queues dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     awaited_responses.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic t_uart_response front_end_step(input t_uart_event ev);
        t_uart_response r;
        r = '0;
        r.status = ST_OK;
        case (ev.action)
            ACT_WRITE: begin
                if (!model_buffered || (tx_fill == 0 && ev.tx_idle)) begin
                    r.send_valid = 1'b1;
                    r.send_byte = ev.data;
                end else if (tx_fill >= TX_DEPTH) begin
                    r.status = ST_TX_FULL;
                end else begin
                    tx_ring[tx_wr] = ev.data;
                    tx_wr = (tx_wr == TX_DEPTH - 1) ? 0 : tx_wr + 1;
                    tx_fill++;
                end
            end
            ACT_TX_DONE: begin
                if (model_buffered && tx_fill > 0) begin
                    r.send_valid = 1'b1;
                    r.send_byte = tx_ring[tx_rd];
                    tx_rd = (tx_rd == TX_DEPTH - 1) ? 0 : tx_rd + 1;
                    tx_fill--;
                end
            end
            ACT_RECEIVE: begin
                if (model_buffered) begin
                    if (ev.frame_err || ev.overrun_err || ev.parity_err) begin
                        r.status = ST_ERRORED;
                    end else if (rx_fill >= RX_DEPTH) begin
                        r.status = ST_RX_OVERFLOW;
                    end else begin
                        rx_ring[rx_wr] = ev.data;
                        rx_wr = (rx_wr == RX_DEPTH - 1) ? 0 : rx_wr + 1;
                        rx_fill++;
                    end
                end else if (holding_full) begin
                    r.status = ST_RX_OVERFLOW;
                end else begin
                    holding_byte = ev.data;
                    holding_full = 1'b1;
                end
            end
            ACT_READ: begin
                if (model_buffered) begin
                    if (rx_fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.read_valid = 1'b1;
                        r.read_byte = rx_ring[rx_rd];
                        rx_rd = (rx_rd == RX_DEPTH - 1) ? 0 : rx_rd + 1;
                        rx_fill--;
                    end
                end else if (holding_full) begin
                    r.read_valid = 1'b1;
                    r.read_byte = holding_byte;
                    holding_full = 1'b0;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            ACT_CLEAR_RX: begin
                rx_wr = 0;
                rx_rd = 0;
                rx_fill = 0;
                holding_full = 1'b0;
            end
            ACT_CLEAR_TX: begin
                tx_wr = 0;
                tx_rd = 0;
                tx_fill = 0;
            end
            default: begin
            end
        endcase
        r.rx_count = COUNT_W'(rx_fill);
        r.tx_count = COUNT_W'(tx_fill);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_uart_response want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_responses.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected", $time);
                mismatches++;
            end else begin
                want = awaited_responses.pop_front();
                check_field("send_valid", 32'(want.send_valid), 32'(o_send_valid));
                check_field("send_byte", 32'(want.send_byte), 32'(o_send_byte));
                check_field("read_valid", 32'(want.read_valid), 32'(o_read_valid));
                check_field("read_byte", 32'(want.read_byte), 32'(o_read_byte));
                check_field("receive_count", 32'(want.rx_count), 32'(o_receive_count));
                check_field("transmit_count", 32'(want.tx_count), 32'(o_transmit_count));
                check_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    task automatic send_event(input t_uart_event ev);
        i_valid = 1'b1;
        i_action = ev.action;
        i_data_byte = ev.data;
        i_transmitter_idle = ev.tx_idle;
        i_frame_error = ev.frame_err;
        i_overrun_error = ev.overrun_err;
        i_parity_error = ev.parity_err;
        do @(posedge i_clk); while (!o_ready);
        awaited_responses.push_back(front_end_step(ev));
        @(negedge i_clk);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic issue(input t_action action, input t_byte data, input logic tx_idle = 1'b1,
                         input logic fe = 1'b0, input logic oe = 1'b0, input logic pe = 1'b0);
        t_uart_event ev;
        ev.action = action;
        ev.data = data;
        ev.tx_idle = tx_idle;
        ev.frame_err = fe;
        ev.overrun_err = oe;
        ev.parity_err = pe;
        send_event(ev);
    endtask

    task automatic drain_pending();
        i_valid = 1'b0;
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_buffered_mode(input logic mode);
        drain_pending();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_BUFFERED_MODE;
        pwdata = APB_DW'(mode);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        model_buffered = mode;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic test_direct_mode();
        write_buffered_mode(1'b0);
        issue(ACT_WRITE, 8'h00, 1'b0);
        issue(ACT_WRITE, 8'hFF, 1'b1);
        issue(ACT_TX_DONE, 8'h5A);
        issue(ACT_READ, 8'h00);
        issue(ACT_RECEIVE, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b1);
        issue(ACT_RECEIVE, 8'h3C);
        issue(ACT_READ, 8'hFF);
        issue(ACT_RECEIVE, 8'hFF);
        issue(ACT_CLEAR_RX, 8'h00);
        issue(ACT_READ, 8'h00);
        issue(ACT_SPARE_6, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        issue(ACT_SPARE_7, 8'h00, 1'b0);
        issue(ACT_CLEAR_TX, 8'h00);
    endtask

    task automatic test_buffered_mode();
        write_buffered_mode(1'b1);
        issue(ACT_WRITE, 8'h11, 1'b1);
        issue(ACT_WRITE, 8'h22, 1'b0);
        issue(ACT_WRITE, 8'h33, 1'b1);
        issue(ACT_TX_DONE, 8'h00);
        issue(ACT_TX_DONE, 8'h00);
        issue(ACT_TX_DONE, 8'h00);
        issue(ACT_RECEIVE, 8'h81, 1'b1, 1'b1, 1'b0, 1'b0);
        issue(ACT_RECEIVE, 8'h82, 1'b1, 1'b0, 1'b1, 1'b0);
        issue(ACT_RECEIVE, 8'h83, 1'b1, 1'b0, 1'b0, 1'b1);
        issue(ACT_RECEIVE, 8'h00);
        issue(ACT_RECEIVE, 8'hFF);
        issue(ACT_READ, 8'h00);
        issue(ACT_READ, 8'h00);
        issue(ACT_READ, 8'h00);
        issue(ACT_RECEIVE, 8'h77);
        issue(ACT_CLEAR_RX, 8'h00);
        issue(ACT_READ, 8'h00);
        issue(ACT_WRITE, 8'h44, 1'b0);
        issue(ACT_CLEAR_TX, 8'h00);
        issue(ACT_TX_DONE, 8'h00);
        issue(ACT_SPARE_6, 8'h00);
        issue(ACT_SPARE_7, 8'hFF);
    endtask

    task automatic test_ring_limits();
        write_buffered_mode(1'b1);
        for (int k = 0; k <= TX_DEPTH; k++) issue(ACT_WRITE, t_byte'(k), 1'b0);
        for (int k = 0; k <= RX_DEPTH; k++) issue(ACT_RECEIVE, t_byte'(8'hF0 ^ k));
        write_buffered_mode(1'b0);
        issue(ACT_WRITE, 8'h99, 1'b0);
        issue(ACT_TX_DONE, 8'h00);
        issue(ACT_RECEIVE, 8'h55);
        issue(ACT_READ, 8'h00);
        write_buffered_mode(1'b1);
        for (int k = 0; k <= TX_DEPTH; k++) issue(ACT_TX_DONE, 8'h00);
        for (int k = 0; k <= RX_DEPTH; k++) issue(ACT_READ, 8'h00);
    endtask

    task automatic random_phase(input int items);
        int          sent;
        int          run_len;
        int unsigned pick;
        t_uart_event ev;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 28) ev.action = ACT_WRITE;
            else if (pick < 50) ev.action = ACT_TX_DONE;
            else if (pick < 72) ev.action = ACT_RECEIVE;
            else if (pick < 93) ev.action = ACT_READ;
            else if (pick < 95) ev.action = ACT_CLEAR_RX;
            else if (pick < 97) ev.action = ACT_CLEAR_TX;
            else if (pick < 98) ev.action = ACT_SPARE_6;
            else ev.action = ACT_SPARE_7;
            run_len = (pick < 93) ? $urandom_range(20, 1) : 1;
            for (int k = 0; k < run_len && sent < items; k++) begin
                ev.data = t_byte'($urandom_range(255));
                ev.tx_idle = 1'($urandom_range(1));
                ev.frame_err = ($urandom_range(7) == 0);
                ev.overrun_err = ($urandom_range(7) == 0);
                ev.parity_err = ($urandom_range(7) == 0);
                send_event(ev);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        t_idle_kind kinds [RANDOM_PHASES];
        logic       modes [RANDOM_PHASES];
        kinds = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_RECEIVER};
        modes = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_buffered_mode(modes[p]);
            case (kinds[p])
                IDLE_NONE: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                IDLE_SENDER: begin
                    sender_idle_pct = 63;
                    receiver_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 63;
                end
                default: begin
                    sender_idle_pct = 6;
                    receiver_stall_pct = 6;
                end
            endcase
            random_phase(RANDOM_PHASE_ITEMS);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_action = ACT_WRITE;
        i_data_byte = '0;
        i_transmitter_idle = 1'b0;
        i_frame_error = 1'b0;
        i_overrun_error = 1'b0;
        i_parity_error = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_wr = 0;
        tx_rd = 0;
        tx_fill = 0;
        rx_wr = 0;
        rx_rd = 0;
        rx_fill = 0;
        holding_byte = '0;
        holding_full = 1'b0;
        model_buffered = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_direct_mode();
        test_buffered_mode();
        test_ring_limits();
        test_random_traffic();
        drain_pending();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
